// ===== hw/rtl/kpd_pkg.sv =====
// ---------------------------------------------------------------------------
// kpd_pkg: shared types and constants for the keypad scanner
// Phase codes, item and state structs, key table and phase encoding.
// ---------------------------------------------------------------------------
package kpd_pkg;

    localparam int unsigned DEBOUNCE_W       = 10;
    localparam int unsigned THRESH_W         = 20;
    localparam int unsigned US_PER_MS        = 1000;
    localparam int unsigned DEBOUNCE_RESET   = 50;
    localparam logic [THRESH_W-1:0] THRESH_RESET = THRESH_W'(DEBOUNCE_RESET * US_PER_MS);

    localparam logic [3:0] COLS_ALL_HIGH = 4'hF;

    // scan phases, one-hot
    typedef enum logic [4:0] {
        PH_IDLE    = 5'b00001,
        PH_LATCHED = 5'b00010,
        PH_READING = 5'b00100,
        PH_HELD    = 5'b01000,
        PH_TIMING  = 5'b10000
    } t_phase;

    // external phase numbering
    localparam logic [2:0] CODE_IDLE    = 3'd0;
    localparam logic [2:0] CODE_LATCHED = 3'd1;
    localparam logic [2:0] CODE_READING = 3'd2;
    localparam logic [2:0] CODE_HELD    = 3'd3;
    localparam logic [2:0] CODE_TIMING  = 3'd4;

    typedef struct packed {
        logic        edge_seen;
        logic [1:0]  edge_row;
        logic [3:0]  row_levels;
        logic [3:0]  column_levels;
        logic [31:0] now_us;
    } t_item;

    typedef struct packed {
        t_phase      phase;
        logic [1:0]  latched_row;
        logic [31:0] release_start;
        logic [6:0]  decoded_key;
        logic        reversed;
        logic [3:0]  column_out;
        logic [3:0]  row_out;
    } t_state;

    typedef struct packed {
        logic       lines_reversed;
        logic [3:0] column_drive;
        logic [3:0] row_drive;
        logic [6:0] key_char;
        logic       key_done;
        logic [2:0] scan_phase;
    } t_result;

    // keypad legend "123A456B789C*0#D", index column*4+row
    function automatic logic [6:0] key_lookup(input logic [3:0] idx);
        logic [6:0] ch;
        case (idx)
            4'd0:    ch = 7'h31; // 1
            4'd1:    ch = 7'h32; // 2
            4'd2:    ch = 7'h33; // 3
            4'd3:    ch = 7'h41; // A
            4'd4:    ch = 7'h34; // 4
            4'd5:    ch = 7'h35; // 5
            4'd6:    ch = 7'h36; // 6
            4'd7:    ch = 7'h42; // B
            4'd8:    ch = 7'h37; // 7
            4'd9:    ch = 7'h38; // 8
            4'd10:   ch = 7'h39; // 9
            4'd11:   ch = 7'h43; // C
            4'd12:   ch = 7'h2A; // *
            4'd13:   ch = 7'h30; // 0
            4'd14:   ch = 7'h23; // #
            default: ch = 7'h44; // D
        endcase
        return ch;
    endfunction

    function automatic logic [2:0] phase_code(input t_phase ph);
        logic [2:0] code;
        case (ph)
            PH_IDLE:    code = CODE_IDLE;
            PH_LATCHED: code = CODE_LATCHED;
            PH_READING: code = CODE_READING;
            PH_HELD:    code = CODE_HELD;
            PH_TIMING:  code = CODE_TIMING;
            default:    code = CODE_IDLE;
        endcase
        return code;
    endfunction

endpackage

// ===== hw/rtl/kpd_in_stage.sv =====
// ---------------------------------------------------------------------------
// kpd_in_stage: input item register
// Captures one poll item and holds it while the step stage is blocked.
// ---------------------------------------------------------------------------
module kpd_in_stage (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  kpd_pkg::t_item i_item,
    input  logic           i_blocked,
    output logic           o_stall,
    output logic           o_item_valid,
    output kpd_pkg::t_item o_item
);

    logic           r_valid;
    kpd_pkg::t_item r_item;
    logic           n_load;

    // hold only when a captured item cannot move on
    assign o_stall = r_valid & i_blocked;
    assign n_load  = ~o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (n_load) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_load && i_valid) begin
            r_item <= i_item;
        end
    end

    assign o_item_valid = r_valid;
    assign o_item       = r_item;

endmodule

// ===== hw/rtl/kpd_step.sv =====
// ---------------------------------------------------------------------------
// kpd_step: per-tick scan state update
// Next phase, column priority encode, key lookup and release timer compare.
// ---------------------------------------------------------------------------
module kpd_step (
    input  kpd_pkg::t_state              i_state,
    input  kpd_pkg::t_item               i_item,
    input  logic [kpd_pkg::THRESH_W-1:0] i_thresh,
    output kpd_pkg::t_state              o_state,
    output kpd_pkg::t_result             o_result
);

    logic        row_high;
    logic [1:0]  col_idx;
    logic [31:0] elapsed;
    logic        expired;
    logic        done;
    kpd_pkg::t_state nxt;

    assign row_high = i_item.row_levels[i_state.latched_row];
    assign elapsed  = i_item.now_us - i_state.release_start;
    assign expired  = elapsed >= 32'(i_thresh);

    // lowest high column, top column when only it is set
    always_comb begin
        if (i_item.column_levels[0]) begin
            col_idx = 2'd0;
        end else if (i_item.column_levels[1]) begin
            col_idx = 2'd1;
        end else if (i_item.column_levels[2]) begin
            col_idx = 2'd2;
        end else begin
            col_idx = 2'd3;
        end
    end

    always_comb begin
        nxt  = i_state;
        done = 1'b0;
        case (i_state.phase)
            kpd_pkg::PH_IDLE: begin
                if (i_item.edge_seen) begin
                    nxt.latched_row = i_item.edge_row;
                    nxt.phase       = kpd_pkg::PH_LATCHED;
                end
            end
            kpd_pkg::PH_LATCHED: begin
                nxt.column_out = 4'h0;
                nxt.reversed   = 1'b1;
                nxt.row_out    = 4'(1) << i_state.latched_row;
                nxt.phase      = kpd_pkg::PH_READING;
            end
            kpd_pkg::PH_READING: begin
                if (i_item.column_levels != 4'h0) begin
                    nxt.decoded_key = kpd_pkg::key_lookup({col_idx, i_state.latched_row});
                    nxt.row_out     = 4'h0;
                    nxt.reversed    = 1'b0;
                    nxt.column_out  = kpd_pkg::COLS_ALL_HIGH;
                    nxt.phase       = kpd_pkg::PH_HELD;
                end
            end
            kpd_pkg::PH_HELD: begin
                if (!row_high) begin
                    nxt.release_start = i_item.now_us;
                    nxt.phase         = kpd_pkg::PH_TIMING;
                end
            end
            kpd_pkg::PH_TIMING: begin
                if (expired) begin
                    if (row_high) begin
                        nxt.phase = kpd_pkg::PH_HELD;
                    end else begin
                        nxt.phase = kpd_pkg::PH_IDLE;
                        done      = 1'b1;
                    end
                end
            end
            default: begin
                nxt.phase = kpd_pkg::PH_IDLE;
            end
        endcase
    end

    assign o_state = nxt;

    assign o_result.lines_reversed = nxt.reversed;
    assign o_result.column_drive   = nxt.column_out;
    assign o_result.row_drive      = nxt.row_out;
    assign o_result.key_char       = nxt.decoded_key;
    assign o_result.key_done       = done;
    assign o_result.scan_phase     = kpd_pkg::phase_code(nxt.phase);

endmodule

// ===== hw/rtl/matrix_keypad_scan_debounce_top.sv =====
// ---------------------------------------------------------------------------
// matrix_keypad_scan_debounce_top: 4x4 keypad line-reversal scanner
// Scans a 4x4 keypad by line reversal and debounces key release.
// ---------------------------------------------------------------------------
//
// channel   direction  handshake                 payload
// -------   ---------  ------------------------  --------------------------------
// poll in   input      i_valid / o_stall         edge, row, levels, now_us
// result    output     o_valid / i_stall         drives, key char, done, phase
// config    input      i_cfg_valid / o_cfg_ready i_cfg_data (debounce_ms)
//
// every poll item gives exactly one result item, through the input and result registers
// one item per cycle sustained while the result is not stalled: input register, step logic, result register
// the step logic is one state update plus a 32-bit elapsed-time compare
// synchronous active-low reset: idle phase, columns driven high, 50 ms debounce
// a stalled result holds the result register and, once the input register is
//   also full, stalls the poll channel; config writes are always taken
//
module matrix_keypad_scan_debounce_top (
    input  logic        i_clk,
    input  logic        i_rst_n,

    // poll items
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_edge_seen,
    input  logic [1:0]  i_edge_row,
    input  logic [3:0]  i_row_levels,
    input  logic [3:0]  i_column_levels,
    input  logic [31:0] i_now_us,

    // result items
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_lines_reversed,
    output logic [3:0]  o_column_drive,
    output logic [3:0]  o_row_drive,
    output logic [6:0]  o_key_char,
    output logic        o_key_done,
    output logic [2:0]  o_scan_phase,

    // debounce register write
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [kpd_pkg::DEBOUNCE_W-1:0] i_cfg_data
);

    kpd_pkg::t_item   in_item;
    kpd_pkg::t_item   s1_item;
    logic             s1_valid;
    logic             out_blocked;
    logic             fire;

    kpd_pkg::t_state  r_state;
    kpd_pkg::t_state  n_state;
    kpd_pkg::t_result n_result;
    kpd_pkg::t_result r_result;
    logic             r_out_valid;

    // debounce time kept as a microsecond threshold
    logic [kpd_pkg::THRESH_W-1:0] r_thresh;
    logic [kpd_pkg::THRESH_W-1:0] n_thresh;

    assign in_item.edge_seen     = i_edge_seen;
    assign in_item.edge_row      = i_edge_row;
    assign in_item.row_levels    = i_row_levels;
    assign in_item.column_levels = i_column_levels;
    assign in_item.now_us        = i_now_us;

    // result register full and not taken this cycle
    assign out_blocked = r_out_valid & i_stall;
    assign fire        = s1_valid & ~out_blocked;

    kpd_in_stage u_in_stage (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .i_item       (in_item),
        .i_blocked    (out_blocked),
        .o_stall      (o_stall),
        .o_item_valid (s1_valid),
        .o_item       (s1_item)
    );

    kpd_step u_step (
        .i_state  (r_state),
        .i_item   (s1_item),
        .i_thresh (r_thresh),
        .o_state  (n_state),
        .o_result (n_result)
    );

    // ms to us scale on write, so the step only compares
    assign o_cfg_ready = 1'b1;
    assign n_thresh    = kpd_pkg::THRESH_W'(i_cfg_data)
                       * kpd_pkg::THRESH_W'(kpd_pkg::US_PER_MS);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thresh <= kpd_pkg::THRESH_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_thresh <= n_thresh;
        end
    end

    // scan state advances once per item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.phase         <= kpd_pkg::PH_IDLE;
            r_state.latched_row   <= 2'd0;
            r_state.release_start <= 32'd0;
            r_state.decoded_key   <= 7'd0;
            r_state.reversed      <= 1'b0;
            r_state.column_out    <= kpd_pkg::COLS_ALL_HIGH;
            r_state.row_out       <= 4'h0;
        end else if (fire) begin
            r_state <= n_state;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (!out_blocked) begin
            r_out_valid <= s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_result <= n_result;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_lines_reversed = r_result.lines_reversed;
    assign o_column_drive   = r_result.column_drive;
    assign o_row_drive      = r_result.row_drive;
    assign o_key_char       = r_result.key_char;
    assign o_key_done       = r_result.key_done;
    assign o_scan_phase     = r_result.scan_phase;

    // a completed release always lands back in idle
    a_done_idle : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_key_done |-> o_scan_phase == kpd_pkg::CODE_IDLE)
        else $error("key_done outside idle");

    // rows are driven exactly while the lines are reversed, columns released then
    a_reverse_drive : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_lines_reversed == (o_row_drive != 4'h0))
                 && (!o_lines_reversed || o_column_drive == 4'h0))
        else $error("line drive does not match direction");

    // a blocked captured item is kept, not dropped
    a_hold_item : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_valid && out_blocked |=> s1_valid && $stable(s1_item))
        else $error("captured item lost while blocked");

    // scan state only moves when an item is stepped
    a_state_quiet : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !fire |=> $stable(r_state))
        else $error("scan state changed without an item");

endmodule
